// ===== design/appp_pkg.sv =====
// Package of shared types, constants and arithmetic helpers for the access-pressure PRB policy.
package appp_pkg;

  localparam int unsigned BwpW      = 9;
  localparam int unsigned PermilleW = 10;

  localparam logic [PermilleW-1:0] PermilleMax = 10'd1000;
  localparam logic [13:0]          BlendHigh   = 14'd6000;
  localparam logic [13:0]          BlendMed    = 14'd2500;

  localparam logic [PermilleW-1:0] CtrlRatioHigh = 10'd400;
  localparam logic [PermilleW-1:0] CtrlRatioMed  = 10'd300;
  localparam logic [PermilleW-1:0] CtrlRatioLow  = 10'd200;
  localparam logic [PermilleW-1:0] DataRatioHigh = 10'd400;
  localparam logic [PermilleW-1:0] DataRatioMed  = 10'd500;
  localparam logic [PermilleW-1:0] DataRatioLow  = 10'd600;

  typedef enum logic [1:0] {
    CFG_BWP_A = 2'd0,
    CFG_BWP_B = 2'd1,
    CFG_BWP_C = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_ID    = 3'd1,
    STATUS_NO_IQ     = 3'd2,
    STATUS_BAD_BWP   = 3'd3,
    STATUS_BAD_RATIO = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LEVEL_LOW  = 2'd0,
    LEVEL_MED  = 2'd1,
    LEVEL_HIGH = 2'd2
  } level_t;

  typedef struct packed {
    logic [BwpW-1:0] bwp_a;
    logic [BwpW-1:0] bwp_b;
    logic [BwpW-1:0] bwp_c;
  } bwp_cfg_t;

  typedef struct packed {
    logic [15:0]     ue_id;
    logic [BwpW-1:0] bwp_size;
    logic [7:0]      retry_count;
    logic [7:0]      msg3_fail_count;
    logic [7:0]      reject_count;
    logic [7:0]      discard_count;
    logic [15:0]     prior_pressure;
    logic [7:0]      weight_in;
    logic            iq_present;
  } req_t;

  typedef struct packed {
    logic                 accepted;
    status_t              status;
    logic [BwpW-1:0]      control_prbs;
    logic [BwpW-1:0]      data_prbs;
    logic [7:0]           weight_out;
    logic [PermilleW-1:0] now_pressure;
    logic [PermilleW-1:0] smooth_pressure;
    logic [PermilleW-1:0] control_ratio;
    logic [PermilleW-1:0] data_ratio;
    level_t               level;
  } rsp_t;

  // Division by ten through a reciprocal multiply, exact for every 14-bit numerator below 10240.
  function automatic logic [PermilleW-1:0] div10(input logic [13:0] x);
    logic [27:0] prod;
    prod = {14'd0, x} * 28'd13108;
    return prod[26:17];
  endfunction

  // Division by five through a reciprocal multiply, exact for every 11-bit numerator.
  function automatic logic [BwpW-1:0] div5(input logic [10:0] x);
    logic [24:0] prod;
    prod = {14'd0, x} * 25'd3277;
    return prod[22:14];
  endfunction

endpackage

// ===== design/appp_if.sv =====
// Valid/ready channel interfaces for policy requests and policy results.
interface appp_req_if;
  import appp_pkg::*;
  logic            valid;
  logic            ready;
  logic [15:0]     ue_id;
  logic [BwpW-1:0] bwp_size;
  logic [7:0]      retry_count;
  logic [7:0]      msg3_fail_count;
  logic [7:0]      reject_count;
  logic [7:0]      discard_count;
  logic [15:0]     prior_pressure;
  logic [7:0]      weight_in;
  logic            iq_present;

  modport source (
    output valid, ue_id, bwp_size, retry_count, msg3_fail_count, reject_count,
           discard_count, prior_pressure, weight_in, iq_present,
    input  ready
  );
  modport sink (
    input  valid, ue_id, bwp_size, retry_count, msg3_fail_count, reject_count,
           discard_count, prior_pressure, weight_in, iq_present,
    output ready
  );
endinterface

interface appp_rsp_if;
  import appp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [2:0]           status;
  logic [BwpW-1:0]      control_prbs;
  logic [BwpW-1:0]      data_prbs;
  logic [7:0]           weight_out;
  logic [PermilleW-1:0] now_pressure;
  logic [PermilleW-1:0] smooth_pressure;
  logic [PermilleW-1:0] control_ratio;
  logic [PermilleW-1:0] data_ratio;
  logic [1:0]           level;

  modport source (
    output valid, accepted, status, control_prbs, data_prbs, weight_out, now_pressure,
           smooth_pressure, control_ratio, data_ratio, level,
    input  ready
  );
  modport sink (
    input  valid, accepted, status, control_prbs, data_prbs, weight_out, now_pressure,
           smooth_pressure, control_ratio, data_ratio, level,
    output ready
  );
endinterface

// ===== design/appp_cfg_regs.sv =====
// Configuration registers holding the three supported bandwidth-part sizes.
module appp_cfg_regs
  import appp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [BwpW-1:0] cfg_wdata,
  output bwp_cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bwp_a <= 9'd51;
      cfg.bwp_b <= 9'd48;
      cfg.bwp_c <= 9'd106;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BWP_A: cfg.bwp_a <= cfg_wdata;
        CFG_BWP_B: cfg.bwp_b <= cfg_wdata;
        CFG_BWP_C: cfg.bwp_c <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/appp_eval.sv =====
// Combinational pressure evaluation, ratio choice, request guard and PRB conversion.
module appp_eval
  import appp_pkg::*;
(
  input  req_t     req,
  input  bwp_cfg_t cfg,
  output rsp_t     rsp
);

  logic [16:0]          now_raw;
  logic [PermilleW-1:0] now_c;
  logic [PermilleW-1:0] prior_c;
  logic [13:0]          blend;
  level_t               level;
  logic [PermilleW-1:0] cr;
  logic [PermilleW-1:0] dr;
  logic [BwpW-1:0]      p200, p300, p400, p500, p600;
  logic [BwpW-1:0]      cp, dp;
  logic [10:0]          bwp_x;
  logic [9:0]           half_sum;
  logic [10:0]          ratio_sum;
  status_t              status;

  assign now_raw = 17'(req.retry_count) * 17'd100 + 17'(req.msg3_fail_count) * 17'd120
                 + 17'(req.reject_count) * 17'd160 + 17'(req.discard_count) * 17'd40;
  assign now_c   = (now_raw > 17'(PermilleMax)) ? PermilleMax : now_raw[PermilleW-1:0];
  assign prior_c = (req.prior_pressure > 16'(PermilleMax)) ? PermilleMax
                                                           : req.prior_pressure[PermilleW-1:0];
  assign blend   = 14'(prior_c) * 14'd7 + 14'(now_c) * 14'd3 + 14'd5;

  // The smoothed value reaches a threshold exactly when the blend reaches ten times it.
  always_comb begin
    if (blend >= BlendHigh) begin
      level = LEVEL_HIGH;
      cr    = CtrlRatioHigh;
      dr    = DataRatioHigh;
    end else if (blend >= BlendMed) begin
      level = LEVEL_MED;
      cr    = CtrlRatioMed;
      dr    = DataRatioMed;
    end else begin
      level = LEVEL_LOW;
      cr    = CtrlRatioLow;
      dr    = DataRatioLow;
    end
  end

  // Ceiling shares of the bandwidth part for every fixed ratio, chosen afterwards by level.
  assign bwp_x    = 11'(req.bwp_size);
  assign half_sum = 10'(req.bwp_size) + 10'd1;
  assign p200     = div5(bwp_x + 11'd4);
  assign p300     = BwpW'(div10(14'(bwp_x * 11'd3 + 11'd9)));
  assign p400     = div5(bwp_x * 11'd2 + 11'd4);
  assign p500     = half_sum[9:1];
  assign p600     = div5(bwp_x * 11'd3 + 11'd4);

  always_comb begin
    case (level)
      LEVEL_HIGH: begin
        cp = p400;
        dp = p400;
      end
      LEVEL_MED: begin
        cp = p300;
        dp = p500;
      end
      default: begin
        cp = p200;
        dp = p600;
      end
    endcase
  end

  assign ratio_sum = 11'(cr) + 11'(dr);

  always_comb begin
    if (req.ue_id == 16'd0) begin
      status = STATUS_BAD_ID;
    end else if (!req.iq_present) begin
      status = STATUS_NO_IQ;
    end else if (!(req.bwp_size == cfg.bwp_a || req.bwp_size == cfg.bwp_b ||
                   req.bwp_size == cfg.bwp_c)) begin
      status = STATUS_BAD_BWP;
    end else if (cr > PermilleMax || dr > PermilleMax || ratio_sum > 11'(PermilleMax)) begin
      status = STATUS_BAD_RATIO;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    rsp.accepted        = (status == STATUS_OK);
    rsp.status          = status;
    rsp.control_prbs    = rsp.accepted ? cp : '0;
    rsp.data_prbs       = rsp.accepted ? dp : '0;
    rsp.weight_out      = (status == STATUS_BAD_ID) ? 8'd0 : req.weight_in;
    rsp.now_pressure    = now_c;
    rsp.smooth_pressure = div10(blend);
    rsp.control_ratio   = cr;
    rsp.data_ratio      = dr;
    rsp.level           = level;
  end

endmodule

// ===== design/access_pressure_prb_policy_core.sv =====
// Top level of the access-pressure PRB policy: input register, evaluation and result register.
//
// Requests enter on the req channel and results leave on the rsp channel, both valid/ready;
// a transaction happens at a rising edge where valid and ready are both high. Every request
// gives exactly one result, in order.
// The three supported bandwidth-part sizes are written through cfg_wr_en, cfg_index and
// cfg_wdata; an index past the third register is ignored. Write them only while idle.
// A request taken on req is stored in the input register and evaluated, and its result is
// then stored in the result register, from which it is shown on rsp.
// Throughput is one request per cycle while rsp.ready is high: the input register feeds
// a single pass of evaluation logic into the result register, and both advance each cycle.
// When the receiver holds rsp.ready low, the result stays put, the input register still
// takes one more request, and req.ready then drops until the result is taken.
// Reset is synchronous: it empties both registers and restores the sizes 51, 48 and 106.
module access_pressure_prb_policy_core
  import appp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  appp_req_if.sink        req,
  appp_rsp_if.source      rsp,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [BwpW-1:0] cfg_wdata
);

  bwp_cfg_t cfg;
  req_t     req_in;
  req_t     s1_req;
  logic     s1_valid;
  rsp_t     eval_rsp;
  rsp_t     out_rsp;
  logic     out_valid;
  logic     out_adv;

  appp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  appp_eval u_eval (
    .req (s1_req),
    .cfg (cfg),
    .rsp (eval_rsp)
  );

  assign req_in = '{
    ue_id:           req.ue_id,
    bwp_size:        req.bwp_size,
    retry_count:     req.retry_count,
    msg3_fail_count: req.msg3_fail_count,
    reject_count:    req.reject_count,
    discard_count:   req.discard_count,
    prior_pressure:  req.prior_pressure,
    weight_in:       req.weight_in,
    iq_present:      req.iq_present
  };

  assign out_adv   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_adv) begin
      out_rsp <= eval_rsp;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.accepted        = out_rsp.accepted;
  assign rsp.status          = out_rsp.status;
  assign rsp.control_prbs    = out_rsp.control_prbs;
  assign rsp.data_prbs       = out_rsp.data_prbs;
  assign rsp.weight_out      = out_rsp.weight_out;
  assign rsp.now_pressure    = out_rsp.now_pressure;
  assign rsp.smooth_pressure = out_rsp.smooth_pressure;
  assign rsp.control_ratio   = out_rsp.control_ratio;
  assign rsp.data_ratio      = out_rsp.data_ratio;
  assign rsp.level           = out_rsp.level;

`ifndef SYNTHESIS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s1_valid)
    else $error("accepted request did not reach the input register");

  a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_adv) |=> (s1_valid && $stable(s1_req)))
    else $error("input register changed while the result register was stalled");

  a_accept_means_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.accepted) |-> (rsp.status == STATUS_OK))
    else $error("accepted result carries a failure status");

  a_reject_zero_prbs: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.accepted) |-> (rsp.control_prbs == '0 && rsp.data_prbs == '0))
    else $error("rejected result carries PRBs");

  a_level_matches_smooth: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.level == LEVEL_HIGH) == (rsp.smooth_pressure >= 10'd600)))
    else $error("high level disagrees with smoothed pressure");
`endif

endmodule
